[sv/pvep_pkg.sv]
package pvep_pkg;

    localparam int MAX_VERTICES = 256;

    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int MUL_W    = DIFF_W + 1;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int FRAC_W   = 16;
    localparam int DEN_W    = PROD_W;
    localparam int LIM_W    = 24;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int RADIUS_W = 8;
    localparam int KIND_W   = 2;
    localparam int DATA_W   = 40;

    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd2;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_CLOSED = 2'd1;
    localparam logic [1:0] REG_COUNT  = 2'd2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

[sv/polyline_vertex_edge_pick.sv]
// Cursor hit test against a stored polyline. Write beats (tuser = 0) store one
// vertex at vertex_slot. Query beats (tuser = 1) first walk the vertices for
// one whose squared distance is strictly below (hit_radius*16)^2, then the
// edges in order, projecting the cursor onto each edge with a clamped 16-bit
// fraction, and finally the closing edge when line_closed is set and the end
// vertices differ (reported as index 0). Every product goes through one
// shared 18x18 multiplier, and each edge whose projection falls strictly
// inside the segment needs a serial division for its segment parameter; the
// single vertex memory read port sets the per-step read order. The block is
// not ready while a query runs; a finished result sits in the output register
// so a new beat can be taken before it is consumed. Vertices never written
// read back undefined.
module polyline_vertex_edge_pick (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pvep_pkg::DATA_W-1:0]         s_tdata,  // vertex_slot, pos_x, pos_y
    input  logic                                s_tuser,  // mode
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pvep_pkg::DATA_W-1:0]         m_tdata,  // hit_index, near_x, near_y
    output logic [pvep_pkg::KIND_W-1:0]         m_tuser   // hit_kind
);
    import pvep_pkg::*;

    localparam int ADDR_W = $clog2(MAX_VERTICES);

    typedef enum logic [21:0] {
        S_IDLE   = 22'h000001,
        S_LIM    = 22'h000002,
        S_LIM2   = 22'h000004,
        S_V_RD   = 22'h000008,
        S_V_DIF  = 22'h000010,
        S_SQ_X   = 22'h000020,
        S_SQ_Y   = 22'h000040,
        S_SQ_CMP = 22'h000080,
        S_E_RA   = 22'h000100,
        S_E_RB   = 22'h000200,
        S_E_DIF  = 22'h000400,
        S_E_M1   = 22'h000800,
        S_E_M2   = 22'h001000,
        S_E_M3   = 22'h002000,
        S_E_M4   = 22'h004000,
        S_E_CL   = 22'h008000,
        S_E_DIV  = 22'h010000,
        S_E_MT1  = 22'h020000,
        S_E_MT2  = 22'h040000,
        S_E_MT3  = 22'h080000,
        S_E_ERR  = 22'h100000,
        S_DONE   = 22'h200000
    } state_t;

    state_t                     state_reg, state_next;

    // configuration
    logic [RADIUS_W-1:0]        radius_reg;
    logic                       closed_reg;
    logic [COUNT_W-1:0]         count_reg;
    logic                       cfg_wr;

    // vertex memory: {y, x}
    logic [2*COORD_W-1:0]       vmem [MAX_VERTICES];
    logic [2*COORD_W-1:0]       mem_q_reg;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [COORD_W-1:0]  mem_x;
    logic signed [COORD_W-1:0]  mem_y;

    // sequencer and datapath
    logic [COUNT_W-1:0]         n_used;
    logic [COUNT_W-1:0]         i_reg, i_next;
    logic [COUNT_W-1:0]         i_inc;
    logic [COUNT_W-1:0]         n_dec;
    logic                       closing_reg, closing_next;
    logic                       edge_reg, edge_next;
    logic signed [COORD_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [COORD_W-1:0]  ax_reg, ax_next, ay_reg, ay_next;
    logic signed [COORD_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [DIFF_W-1:0]   dx_reg, dx_next, dy_reg, dy_next;
    logic signed [DIFF_W-1:0]   ex_reg, ex_next, ey_reg, ey_next;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;
    logic [DEN_W-1:0]           den_reg, den_next;
    logic [LIM_W-1:0]           lim_reg, lim_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [SUM_W-1:0]    sum;
    logic signed [PROD_W-1:0]   rnd_full;
    logic signed [DIFF_W:0]     rnd_q;

    // divider
    logic                       div_start;
    logic                       div_done;
    logic [FRAC_W-1:0]          div_quo;

    // result
    logic [KIND_W-1:0]          rk_reg, rk_next;
    logic [INDEX_W-1:0]         ri_reg, ri_next;
    logic signed [COORD_W-1:0]  rx_reg, rx_next, ry_reg, ry_next;
    logic                       ov_reg, ov_next;
    logic [KIND_W-1:0]          ok_reg, ok_next;
    logic [DATA_W-1:0]          od_reg, od_next;

    logic                       in_beat;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign s_tready = (state_reg == S_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ok_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_RADIUS: prdata = {24'd0, radius_reg};
            REG_CLOSED: prdata = {31'd0, closed_reg};
            REG_COUNT:  prdata = {23'd0, count_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_W'(20);
            closed_reg <= 1'b0;
            count_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_RADIUS: radius_reg <= pwdata[RADIUS_W-1:0];
                REG_CLOSED: closed_reg <= pwdata[0];
                REG_COUNT:  count_reg  <= pwdata[COUNT_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp the count to the store depth
    assign n_used = (count_reg > COUNT_W'(MAX_VERTICES)) ? COUNT_W'(MAX_VERTICES) : count_reg;
    assign i_inc  = i_reg + 1'b1;
    assign n_dec  = n_used - 1'b1;

    always_comb
    begin
        case (state_reg)
            S_E_RA:  rd_addr = closing_reg ? n_dec[ADDR_W-1:0] : ADDR_W'(i_reg - 1'b1);
            S_E_RB:  rd_addr = closing_reg ? '0 : i_reg[ADDR_W-1:0];
            default: rd_addr = i_reg[ADDR_W-1:0];
        endcase
    end

    // store a write beat; read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (in_beat && s_tuser == MODE_WRITE)
            vmem[ADDR_W'(s_tdata[INDEX_W-1:0])] <= s_tdata[INDEX_W +: 2*COORD_W];
        mem_q_reg <= vmem[rd_addr];
    end

    assign mem_x = mem_q_reg[COORD_W-1:0];
    assign mem_y = mem_q_reg[2*COORD_W-1:COORD_W];

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_LIM:
            begin
                mul_a = MUL_W'(radius_reg);
                mul_b = MUL_W'(radius_reg);
            end
            S_SQ_X:
            begin
                mul_a = MUL_W'(ex_reg);
                mul_b = MUL_W'(ex_reg);
            end
            S_SQ_Y:
            begin
                mul_a = MUL_W'(ey_reg);
                mul_b = MUL_W'(ey_reg);
            end
            S_E_M1:
            begin
                mul_a = MUL_W'(dx_reg);
                mul_b = MUL_W'(dx_reg);
            end
            S_E_M2:
            begin
                mul_a = MUL_W'(dy_reg);
                mul_b = MUL_W'(dy_reg);
            end
            S_E_M3:
            begin
                mul_a = MUL_W'(ex_reg);
                mul_b = MUL_W'(dx_reg);
            end
            S_E_M4:
            begin
                mul_a = MUL_W'(ey_reg);
                mul_b = MUL_W'(dy_reg);
            end
            S_E_MT1:
            begin
                mul_a = $signed({2'b00, div_quo});
                mul_b = MUL_W'(dx_reg);
            end
            S_E_MT2:
            begin
                mul_a = $signed({2'b00, div_quo});
                mul_b = MUL_W'(dy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign sum      = acc_reg + SUM_W'(prod_reg);
    // round half up: floor((t*d + 2^15) / 2^16)
    assign rnd_full = prod_reg + PROD_W'(32768);
    assign rnd_q    = rnd_full[FRAC_W +: DIFF_W+1];

    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        closing_next = closing_reg;
        edge_next    = edge_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        acc_next     = acc_reg;
        den_next     = den_reg;
        lim_next     = lim_reg;
        rk_next      = rk_reg;
        ri_next      = ri_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        ov_next      = ov_reg && !m_tready;
        ok_next      = ok_reg;
        od_next      = od_reg;
        div_start    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat && s_tuser == MODE_QUERY)
                begin
                    cx_next    = s_tdata[INDEX_W +: COORD_W];
                    cy_next    = s_tdata[INDEX_W+COORD_W +: COORD_W];
                    state_next = S_LIM;
                end
            end
            S_LIM:
            begin
                // clear the result, square the radius
                rk_next      = KIND_NONE;
                ri_next      = '0;
                rx_next      = '0;
                ry_next      = '0;
                i_next       = '0;
                edge_next    = 1'b0;
                closing_next = 1'b0;
                state_next   = S_LIM2;
            end
            S_LIM2:
            begin
                lim_next   = {prod_reg[2*RADIUS_W-1:0], 8'd0};
                state_next = (n_used == '0) ? S_DONE : S_V_RD;
            end
            S_V_RD:
                state_next = S_V_DIF;
            S_V_DIF:
            begin
                ex_next    = DIFF_W'(mem_x) - DIFF_W'(cx_reg);
                ey_next    = DIFF_W'(mem_y) - DIFF_W'(cy_reg);
                state_next = S_SQ_X;
            end
            S_SQ_X:
                state_next = S_SQ_Y;
            S_SQ_Y:
            begin
                acc_next   = SUM_W'(prod_reg);
                state_next = S_SQ_CMP;
            end
            S_SQ_CMP:
            begin
                if (sum < $signed(SUM_W'(lim_reg)))
                begin
                    // hit: record and finish
                    rk_next    = edge_reg ? KIND_EDGE : KIND_VERTEX;
                    ri_next    = closing_reg ? '0 : i_reg[INDEX_W-1:0];
                    rx_next    = edge_reg ? px_reg : '0;
                    ry_next    = edge_reg ? py_reg : '0;
                    state_next = S_DONE;
                end
                else if (!edge_reg)
                begin
                    if (i_inc == n_used)
                    begin
                        if (n_used >= COUNT_W'(2))
                        begin
                            edge_next  = 1'b1;
                            i_next     = COUNT_W'(1);
                            state_next = S_E_RA;
                        end
                        else
                            state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_inc;
                        state_next = S_V_RD;
                    end
                end
                else if (closing_reg)
                    state_next = S_DONE;
                else if (i_inc == n_used)
                begin
                    if (closed_reg)
                    begin
                        closing_next = 1'b1;
                        state_next   = S_E_RA;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_E_RA;
                end
            end
            S_E_RA:
                state_next = S_E_RB;
            S_E_RB:
            begin
                ax_next    = mem_x;
                ay_next    = mem_y;
                state_next = S_E_DIF;
            end
            S_E_DIF:
            begin
                dx_next = DIFF_W'(mem_x) - DIFF_W'(ax_reg);
                dy_next = DIFF_W'(mem_y) - DIFF_W'(ay_reg);
                ex_next = DIFF_W'(cx_reg) - DIFF_W'(ax_reg);
                ey_next = DIFF_W'(cy_reg) - DIFF_W'(ay_reg);
                // closing edge with equal ends does not count
                if (closing_reg && mem_x == ax_reg && mem_y == ay_reg)
                    state_next = S_DONE;
                else
                    state_next = S_E_M1;
            end
            S_E_M1:
                state_next = S_E_M2;
            S_E_M2:
            begin
                acc_next   = SUM_W'(prod_reg);
                state_next = S_E_M3;
            end
            S_E_M3:
            begin
                den_next   = sum[DEN_W-1:0];
                state_next = S_E_M4;
            end
            S_E_M4:
            begin
                acc_next   = SUM_W'(prod_reg);
                state_next = S_E_CL;
            end
            S_E_CL:
            begin
                // clamp the projection
                if (den_reg == '0 || sum <= 0)
                begin
                    px_next    = ax_reg;
                    py_next    = ay_reg;
                    state_next = S_E_ERR;
                end
                else if (sum >= $signed({1'b0, den_reg}))
                begin
                    px_next    = COORD_W'(ax_reg + dx_reg);
                    py_next    = COORD_W'(ay_reg + dy_reg);
                    state_next = S_E_ERR;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_E_DIV;
                end
            end
            S_E_DIV:
            begin
                if (div_done)
                    state_next = S_E_MT1;
            end
            S_E_MT1:
                state_next = S_E_MT2;
            S_E_MT2:
            begin
                px_next    = COORD_W'(ax_reg + rnd_q);
                state_next = S_E_MT3;
            end
            S_E_MT3:
            begin
                py_next    = COORD_W'(ay_reg + rnd_q);
                state_next = S_E_ERR;
            end
            S_E_ERR:
            begin
                ex_next    = DIFF_W'(px_reg) - DIFF_W'(cx_reg);
                ey_next    = DIFF_W'(py_reg) - DIFF_W'(cy_reg);
                state_next = S_SQ_X;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!ov_reg || m_tready)
                begin
                    ov_next    = 1'b1;
                    ok_next    = rk_reg;
                    od_next    = {ry_reg, rx_reg, ri_reg};
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            closing_reg <= 1'b0;
            edge_reg    <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            closing_reg <= closing_next;
            edge_reg    <= edge_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg  <= cx_next;
        cy_reg  <= cy_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        ex_reg  <= ex_next;
        ey_reg  <= ey_next;
        acc_reg <= acc_next;
        den_reg <= den_next;
        lim_reg <= lim_next;
        rk_reg  <= rk_next;
        ri_reg  <= ri_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        ok_reg  <= ok_next;
        od_reg  <= od_next;
    end

    pvep_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum[DEN_W-1:0]),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    a_done_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_E_DIV)
        else $error("divider finished outside the division step");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> ok_reg == KIND_NONE || ok_reg == KIND_VERTEX || ok_reg == KIND_EDGE)
        else $error("illegal hit kind");

    a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ok_reg != KIND_EDGE |-> od_reg[DATA_W-1:INDEX_W] == '0)
        else $error("near point set without an edge hit");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ok_reg == KIND_NONE |-> od_reg[INDEX_W-1:0] == '0)
        else $error("index set without a hit");

endmodule

[sv/pvep_div.sv]
module pvep_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pvep_pkg::DEN_W-1:0]      num,
    input  logic [pvep_pkg::DEN_W-1:0]      den,
    output logic                            done,
    output logic [pvep_pkg::FRAC_W-1:0]     quo
);
    import pvep_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W);

    logic [DEN_W:0]       rem_reg;
    logic [DEN_W:0]       rem_next;
    logic [FRAC_W-1:0]    q_reg;
    logic [FRAC_W-1:0]    q_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DEN_W+1:0]     shifted;

    // one quotient bit per cycle, restoring form
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, 1'b0};
        if (start)
        begin
            rem_next  = {1'b0, num};
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {2'b00, den})
            begin
                rem_next = (DEN_W+1)'(shifted - {2'b00, den});
                q_next   = {q_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W:0];
                q_next   = {q_reg[FRAC_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(FRAC_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            q_reg    <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_no_restart_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> busy_reg || done_reg)
        else $error("divider stopped without done");

    a_quotient_held: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !start |=> $stable(q_reg))
        else $error("quotient changed while idle");

endmodule
